@@ rtl/stepd_pkg.sv @@
// Shared types, codes and constants of the stepper step generator.
// No dependencies; every other file of the block refers to it by scoped name.
package stepd_pkg;

  localparam int unsigned RAMP_SCALE = 100;
  localparam int unsigned INC_W      = 14;
  localparam int unsigned VEL_W      = 24;
  localparam int unsigned DVD_W      = 20;
  localparam int unsigned CNT_W      = $clog2(DVD_W + 1);
  localparam logic [DVD_W-1:0] STEP_US_NUM = DVD_W'(1000000);
  localparam logic [31:0] START_DELAY = 32'd10;

  localparam logic [3:0] MODE_TICK    = 4'd0;
  localparam logic [3:0] MODE_ABS     = 4'd1;
  localparam logic [3:0] MODE_REL     = 4'd2;
  localparam logic [3:0] MODE_HOME    = 4'd3;
  localparam logic [3:0] MODE_TO_LOW  = 4'd4;
  localparam logic [3:0] MODE_TO_UP   = 4'd5;
  localparam logic [3:0] MODE_ENABLE  = 4'd6;
  localparam logic [3:0] MODE_DISABLE = 4'd7;
  localparam logic [3:0] MODE_ESTOP   = 4'd8;
  localparam logic [3:0] MODE_SETHOME = 4'd9;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ENABLED  = 3'd1;
  localparam logic [2:0] ST_DISABLED = 3'd2;
  localparam logic [2:0] ST_RUNNING  = 3'd3;
  localparam logic [2:0] ST_ESTOP    = 3'd4;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_COMPLETE = 3'd1;
  localparam logic [2:0] EV_RANGE_LO = 3'd2;
  localparam logic [2:0] EV_RANGE_UP = 3'd3;
  localparam logic [2:0] EV_SW_LO    = 3'd4;
  localparam logic [2:0] EV_SW_UP    = 3'd5;

  localparam logic [2:0] CFG_LOWER    = 3'd0;
  localparam logic [2:0] CFG_UPPER    = 3'd1;
  localparam logic [2:0] CFG_RAMP     = 3'd2;
  localparam logic [2:0] CFG_HOMESPD  = 3'd3;
  localparam logic [2:0] CFG_LSW_PRES = 3'd4;
  localparam logic [2:0] CFG_USW_PRES = 3'd5;

  localparam logic [3:0] COIL_P0 = 4'h3;
  localparam logic [3:0] COIL_P1 = 4'h6;
  localparam logic [3:0] COIL_P2 = 4'hC;
  localparam logic [3:0] COIL_P3 = 4'h9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic prep;
    logic ramp;
    logic div_start;
    logic finish;
    logic load_out;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic is_tick;
    logic is_move;
    logic inc_zero;
    logic tick_div;
    logic div_done;
  } sts_t;

  function automatic logic [3:0] coil_of(input logic [1:0] phase);
    logic [3:0] p;
    case (phase)
      2'd0:    p = COIL_P0;
      2'd1:    p = COIL_P1;
      2'd2:    p = COIL_P2;
      default: p = COIL_P3;
    endcase
    return p;
  endfunction

  function automatic logic [INC_W-1:0] vel_inc(input logic [3:0] setting);
    logic [INC_W-1:0] r;
    if (setting == 4'd0) r = '0;
    else r = INC_W'(RAMP_SCALE * (10 - int'(setting)));
    return r;
  endfunction

endpackage

@@ rtl/stepd_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Uses stepd_pkg widths.
module stepd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [stepd_pkg::DVD_W-1:0]  dividend,
  input  logic [stepd_pkg::VEL_W-1:0]  divisor,
  output logic                         done,
  output logic [stepd_pkg::DVD_W-1:0]  quotient
);

  logic [stepd_pkg::VEL_W-1:0] rem_r, rem_nxt;
  logic [stepd_pkg::DVD_W-1:0] q_r, q_nxt;
  logic [stepd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [stepd_pkg::VEL_W:0] trial;
  logic [stepd_pkg::VEL_W:0] dsr_ext;

  assign trial   = {rem_r, q_r[stepd_pkg::DVD_W-1]};
  assign dsr_ext = {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = dividend;
      cnt_nxt  = stepd_pkg::CNT_W'(stepd_pkg::DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= dsr_ext) begin
        rem_nxt = stepd_pkg::VEL_W'(trial - dsr_ext);
        q_nxt   = {q_r[stepd_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[stepd_pkg::VEL_W-1:0];
        q_nxt   = {q_r[stepd_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == stepd_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ rtl/stepd_datapath.sv @@
// Motor state, configuration registers, item capture and result register.
// Uses stepd_pkg and stepd_div; sequenced by stepd_ctrl.
module stepd_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  stepd_pkg::cmd_t     cmd,
  output stepd_pkg::sts_t     sts,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [3:0]          in_mode,
  input  logic signed [31:0]  in_target_or_steps,
  input  logic [13:0]         in_speed,
  input  logic                in_lower_switch,
  input  logic                in_upper_switch,
  output logic [3:0]          out_coil_drive,
  output logic [2:0]          out_motor_status,
  output logic [2:0]          out_run_event,
  output logic signed [31:0]  out_current_position,
  output logic signed [31:0]  out_moved_steps,
  output logic                out_is_homed,
  output logic                out_stepped
);

  // configuration
  logic signed [31:0] lower_r;
  logic [30:0] upper_r;
  logic [3:0]  ramp_r;
  logic [13:0] homespd_r;
  logic        lsw_pres_r, usw_pres_r;

  // captured word
  logic [3:0]         mode_q_r;
  logic signed [31:0] arg_q_r;
  logic [13:0]        spd_q_r;
  logic               lsw_q_r, usw_q_r;

  // motor state
  logic [2:0]  mmode_r;
  logic        home_r;
  logic signed [31:0] pos_r;
  logic [31:0] delta_r;
  logic signed [31:0] tgt_r;
  logic        back_r;
  logic [1:0]  phase_r;
  logic [3:0]  coil_r;
  logic [stepd_pkg::VEL_W-1:0] vel_r;
  logic [13:0] peak_r;
  logic [31:0] rus_r, rds_r, time_r, nst_r;
  logic [stepd_pkg::INC_W-1:0] inc_r;
  logic [31:0] total_r;
  logic [2:0]  event_r;
  logic        stepped_r, step_ok_r;

  // divider
  logic        div_done;
  logic [stepd_pkg::DVD_W-1:0] div_q, div_dvd;
  logic [stepd_pkg::VEL_W-1:0] div_dsr;

  logic is_tick, is_move, is_homecmd;
  assign is_tick    = (mode_q_r == stepd_pkg::MODE_TICK);
  assign is_homecmd = (mode_q_r == stepd_pkg::MODE_HOME) || (mode_q_r == stepd_pkg::MODE_TO_LOW)
                   || (mode_q_r == stepd_pkg::MODE_TO_UP);
  assign is_move = (mode_q_r == stepd_pkg::MODE_ABS) || is_homecmd
                || ((mode_q_r == stepd_pkg::MODE_REL) && (arg_q_r != 32'sd0));

  // move target, with saturation of the relative sum
  logic signed [32:0] rel_sum;
  logic signed [31:0] mv_tgt;
  logic [13:0]        mv_spd;
  assign rel_sum = 33'(pos_r) + 33'(arg_q_r);

  always_comb begin
    mv_spd = homespd_r;
    case (mode_q_r)
      stepd_pkg::MODE_ABS: begin
        mv_tgt = arg_q_r;
        mv_spd = spd_q_r;
      end
      stepd_pkg::MODE_REL: begin
        mv_spd = spd_q_r;
        if (rel_sum > 33'sh0_7FFF_FFFF)      mv_tgt = 32'sh7FFF_FFFF;
        else if (rel_sum < -33'sh0_8000_0000) mv_tgt = 32'sh8000_0000;
        else                                  mv_tgt = rel_sum[31:0];
      end
      stepd_pkg::MODE_TO_LOW: mv_tgt = lower_r;
      stepd_pkg::MODE_TO_UP:  mv_tgt = $signed({1'b0, upper_r});
      default:                mv_tgt = 32'sd0;
    endcase
  end

  // tick: due check and limit checks
  logic [31:0] time_inc;
  logic        due;
  logic signed [32:0] next_pos;
  assign time_inc = time_r + 32'd1;
  assign due = home_r && (mmode_r == stepd_pkg::ST_RUNNING) && (time_inc >= nst_r);
  assign next_pos = back_r ? (33'(pos_r) - 33'sd1) : (33'(pos_r) + 33'sd1);

  // velocity ramp; the step increment follows the current ramp setting
  logic [31:0] count;
  logic [stepd_pkg::VEL_W-1:0] vel_ramp, inc_ext, ramp_inc;
  assign count    = delta_r[31] ? (32'd0 - delta_r) : delta_r;
  assign inc_ext  = stepd_pkg::VEL_W'(inc_r);
  assign ramp_inc = stepd_pkg::VEL_W'(stepd_pkg::vel_inc(ramp_r));
  always_comb begin
    vel_ramp = vel_r;
    if (count <= rus_r)      vel_ramp = vel_r + ramp_inc;
    else if (count > rds_r)  vel_ramp = (vel_r > ramp_inc) ? (vel_r - ramp_inc) : '0;
  end

  // move finish
  logic [31:0] q_mv;
  assign q_mv = (inc_r == '0) ? 32'd0 : 32'(div_q);

  assign div_dvd = is_tick ? stepd_pkg::STEP_US_NUM : stepd_pkg::DVD_W'(peak_r);
  assign div_dsr = is_tick ? vel_r : inc_ext;

  stepd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sts.is_tick  = is_tick;
  assign sts.is_move  = is_move;
  assign sts.inc_zero = (inc_r == '0);
  assign sts.tick_div = step_ok_r && (vel_ramp != '0);
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r    <= -32'sd2000000000;
      upper_r    <= 31'd2000000000;
      ramp_r     <= 4'd5;
      homespd_r  <= 14'd100;
      lsw_pres_r <= 1'b0;
      usw_pres_r <= 1'b0;
      mmode_r    <= stepd_pkg::ST_IDLE;
      home_r     <= 1'b0;
      pos_r      <= '0;
      delta_r    <= '0;
      tgt_r      <= '0;
      back_r     <= 1'b0;
      phase_r    <= '0;
      coil_r     <= '0;
      vel_r      <= '0;
      peak_r     <= '0;
      rus_r      <= '0;
      rds_r      <= '0;
      time_r     <= '0;
      nst_r      <= '1;
      mode_q_r   <= stepd_pkg::MODE_TICK;
      inc_r      <= '0;
      step_ok_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          stepd_pkg::CFG_LOWER:
            if (cfg_data[31] || (cfg_data == 32'd0)) lower_r <= $signed(cfg_data);
          stepd_pkg::CFG_UPPER:    upper_r <= cfg_data[30:0];
          stepd_pkg::CFG_RAMP:
            if (cfg_data[3:0] <= 4'd9) ramp_r <= cfg_data[3:0];
          stepd_pkg::CFG_HOMESPD:  homespd_r  <= cfg_data[13:0];
          stepd_pkg::CFG_LSW_PRES: lsw_pres_r <= cfg_data[0];
          stepd_pkg::CFG_USW_PRES: usw_pres_r <= cfg_data[0];
          default: ;
        endcase
      end

      if (cmd.capture) mode_q_r <= in_mode;

      if (cmd.exec) begin
        step_ok_r <= 1'b0;
        if (is_tick) begin
          time_r <= time_inc;
          if (due) begin
            if (pos_r == tgt_r) begin
              mmode_r <= stepd_pkg::ST_ENABLED;
            end else if (next_pos < 33'(lower_r)) begin
              mmode_r <= stepd_pkg::ST_ENABLED;
            end else if (next_pos > $signed({2'b00, upper_r})) begin
              mmode_r <= stepd_pkg::ST_ENABLED;
            end else begin
              coil_r  <= stepd_pkg::coil_of(phase_r);
              phase_r <= back_r ? (phase_r - 2'd1) : (phase_r + 2'd1);
              pos_r   <= next_pos[31:0];
              delta_r <= back_r ? (delta_r - 32'd1) : (delta_r + 32'd1);
              if ((lsw_pres_r && !lsw_q_r) || (usw_pres_r && !usw_q_r))
                mmode_r <= stepd_pkg::ST_ENABLED;
              else
                step_ok_r <= 1'b1;
            end
          end
        end else if (is_move) begin
          tgt_r   <= mv_tgt;
          peak_r  <= mv_spd;
          inc_r   <= stepd_pkg::vel_inc(ramp_r);
          delta_r <= '0;
          nst_r   <= time_r + stepd_pkg::START_DELAY;
          mmode_r <= stepd_pkg::ST_RUNNING;
        end else begin
          case (mode_q_r)
            stepd_pkg::MODE_ENABLE: begin
              // enable always lands in the enabled state, so home is set too
              mmode_r <= stepd_pkg::ST_ENABLED;
              coil_r  <= stepd_pkg::coil_of(phase_r);
              phase_r <= back_r ? (phase_r - 2'd1) : (phase_r + 2'd1);
              pos_r   <= '0;
              delta_r <= '0;
              home_r  <= 1'b1;
            end
            stepd_pkg::MODE_DISABLE: begin
              coil_r  <= '0;
              mmode_r <= stepd_pkg::ST_DISABLED;
              home_r  <= 1'b0;
            end
            stepd_pkg::MODE_ESTOP: begin
              coil_r  <= '0;
              mmode_r <= stepd_pkg::ST_ESTOP;
              home_r  <= 1'b0;
              tgt_r   <= pos_r;
            end
            stepd_pkg::MODE_SETHOME: begin
              if (mmode_r == stepd_pkg::ST_ENABLED) begin
                pos_r   <= '0;
                delta_r <= '0;
                home_r  <= 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      if (cmd.prep) back_r <= (tgt_r < pos_r);

      if (cmd.ramp && step_ok_r) vel_r <= vel_ramp;

      if (cmd.finish) begin
        if (is_tick) begin
          nst_r <= nst_r + 32'(div_q);
        end else begin
          vel_r <= (q_mv == 32'd0) ? stepd_pkg::VEL_W'(peak_r) : '0;
          if ({1'b0, total_r} > {q_mv, 1'b0}) begin
            rus_r <= q_mv;
            rds_r <= total_r - q_mv;
          end else begin
            rus_r <= {1'b0, total_r[31:1]};
            rds_r <= {1'b0, total_r[31:1]};
          end
        end
      end
    end
  end

  // payload registers: captured word, event, distance, result word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      arg_q_r   <= in_target_or_steps;
      spd_q_r   <= in_speed;
      lsw_q_r   <= in_lower_switch;
      usw_q_r   <= in_upper_switch;
      event_r   <= stepd_pkg::EV_NONE;
      stepped_r <= 1'b0;
    end
    if (cmd.exec) begin
      if (is_tick && due) begin
        if (pos_r == tgt_r)                                 event_r <= stepd_pkg::EV_COMPLETE;
        else if (next_pos < 33'(lower_r))                   event_r <= stepd_pkg::EV_RANGE_LO;
        else if (next_pos > $signed({2'b00, upper_r}))      event_r <= stepd_pkg::EV_RANGE_UP;
        else begin
          stepped_r <= 1'b1;
          if (lsw_pres_r && !lsw_q_r)      event_r <= stepd_pkg::EV_SW_LO;
          else if (usw_pres_r && !usw_q_r) event_r <= stepd_pkg::EV_SW_UP;
        end
      end
      if (mode_q_r == stepd_pkg::MODE_ENABLE) stepped_r <= 1'b1;
    end
    if (cmd.prep) total_r <= (tgt_r < pos_r) ? 32'(pos_r - tgt_r) : 32'(tgt_r - pos_r);
    if (cmd.load_out) begin
      out_coil_drive       <= coil_r;
      out_motor_status     <= mmode_r;
      out_run_event        <= event_r;
      out_current_position <= pos_r;
      out_moved_steps      <= $signed(delta_r);
      out_is_homed         <= home_r;
      out_stepped          <= stepped_r;
    end
  end

endmodule

@@ rtl/stepd_ctrl.sv @@
// Sequencer for one word at a time and the result valid flag.
// Uses stepd_pkg command and status structs.
module stepd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output stepd_pkg::cmd_t cmd,
  input  stepd_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_PREP, S_RAMP, S_DIV, S_WAIT, S_FIN, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_tick)      state_nxt = S_RAMP;
        else if (sts.is_move) state_nxt = S_PREP;
        else                  state_nxt = S_DONE;
      end
      S_PREP: state_nxt = sts.inc_zero ? S_FIN : S_DIV;
      S_RAMP: begin
        cmd.ramp  = 1'b1;
        state_nxt = sts.tick_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: if (sts.div_done) state_nxt = S_FIN;
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.prep = (state_r == S_PREP);
  end

  always_comb begin
    if (cmd.load_out)  out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else               out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/stepper_trapezoid_step_generator.sv @@
// Top level of the trapezoidal-ramp stepper step generator.
// Joins stepd_ctrl and stepd_datapath; uses stepd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): one word per tick or command. A tick
//   (mode 0) carries the limit switch levels; other modes start moves,
//   enable, disable, stop or set home.
//   Result channel (out_valid/out_ready): exactly one result word per input
//   word, in order, carrying coil drive, status, event and position.
//   Config port (cfg_we/cfg_index/cfg_data): write soft limits, ramp
//   setting, homing speed and switch presence while no word is in flight.
// Sequencing:
//   One word at a time. Moves with a ramp and ticks that schedule a step
//   wait for the restoring divider, which forms both the ramp length
//   (speed / increment) and the step period (1000000 / velocity). Other
//   words do not use the divider.
// Reset:
//   rst_n low clears the motor to reset idle, unhomed, coils off, step time
//   all ones, and restores the default configuration.
// Stall:
//   The result register holds while out_ready is low; the next word is
//   still accepted and worked, and waits before loading the result register.
module stepper_trapezoid_step_generator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_mode,
  input  logic signed [31:0] in_target_or_steps,
  input  logic [13:0]        in_speed,
  input  logic               in_lower_switch,
  input  logic               in_upper_switch,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_coil_drive,
  output logic [2:0]         out_motor_status,
  output logic [2:0]         out_run_event,
  output logic signed [31:0] out_current_position,
  output logic signed [31:0] out_moved_steps,
  output logic               out_is_homed,
  output logic               out_stepped
);

  stepd_pkg::cmd_t cmd;
  stepd_pkg::sts_t sts;

  // sequencing: one word in flight, result register decoupled
  stepd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // motor state, ramp arithmetic, shared divider
  stepd_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_mode              (in_mode),
    .in_target_or_steps   (in_target_or_steps),
    .in_speed             (in_speed),
    .in_lower_switch      (in_lower_switch),
    .in_upper_switch      (in_upper_switch),
    .out_coil_drive       (out_coil_drive),
    .out_motor_status     (out_motor_status),
    .out_run_event        (out_run_event),
    .out_current_position (out_current_position),
    .out_moved_steps      (out_moved_steps),
    .out_is_homed         (out_is_homed),
    .out_stepped          (out_stepped)
  );

endmodule

@@ rtl/stepd_checker.sv @@
// Port-level checks of the step generator, bound to the top level.
// Uses stepd_pkg codes.
module stepd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_coil_drive,
  input logic [2:0] out_motor_status,
  input logic [2:0] out_run_event,
  input logic       out_is_homed,
  input logic       out_stepped
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_step_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stepped |->
      (out_coil_drive == stepd_pkg::COIL_P0) || (out_coil_drive == stepd_pkg::COIL_P1) ||
      (out_coil_drive == stepd_pkg::COIL_P2) || (out_coil_drive == stepd_pkg::COIL_P3))
    else $error("step with an invalid coil pattern");

  a_event_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_run_event != stepd_pkg::EV_NONE) |->
      out_motor_status == stepd_pkg::ST_ENABLED)
    else $error("run event without leaving the running state");

  a_off_unhomed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_motor_status == stepd_pkg::ST_DISABLED) ||
                  (out_motor_status == stepd_pkg::ST_ESTOP)) |->
      (out_coil_drive == 4'd0) && !out_is_homed)
    else $error("coils live or homed after disable");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stepper_trapezoid_step_generator stepd_checker u_stepd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_coil_drive   (out_coil_drive),
  .out_motor_status (out_motor_status),
  .out_run_event    (out_run_event),
  .out_is_homed     (out_is_homed),
  .out_stepped      (out_stepped)
);

@@ tb/sv/tb_stepper_trapezoid_step_generator.sv @@
// Testbench for the trapezoidal-ramp stepper step generator: random and directed
// ticks and commands, a cycle-free predictor in a scoreboard class, idle phases.
// Depends on rtl/stepd_pkg.sv and rtl/stepper_trapezoid_step_generator.sv.
`timescale 1ns / 100ps

typedef struct {
  logic [3:0]         coil;
  logic [2:0]         status;
  logic [2:0]         ev;
  logic signed [31:0] pos;
  logic signed [31:0] moved;
  logic               homed;
  logic               stepped;
} motor_word_t;

class motor_scoreboard;
  // configuration copy
  logic signed [31:0] lo_lim;
  logic [30:0] up_lim;
  logic [3:0]  ramp_set;
  logic [13:0] home_spd;
  logic        lsw_pres, usw_pres;
  // motor state copy
  logic [2:0]  mmode;
  logic        homed;
  logic signed [31:0] pos, tgt;
  logic [31:0] delta;
  logic        backward;
  logic [1:0]  phase;
  logic [3:0]  pattern;
  logic [31:0] vel, ramp_up, ramp_dn, now, next_t;
  motor_word_t pending[$];
  int errors, checked, steps_seen, events_seen;

  function new();
    lo_lim = -32'sd2000000000; up_lim = 31'd2000000000; ramp_set = 4'd5;
    home_spd = 14'd100; lsw_pres = 0; usw_pres = 0;
    mmode = stepd_pkg::ST_IDLE; homed = 0; pos = 0; tgt = 0; delta = 0; backward = 0;
    phase = 0; pattern = 0; vel = 0; ramp_up = 0; ramp_dn = 0; now = 0;
    next_t = '1; errors = 0; checked = 0; steps_seen = 0; events_seen = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] d);
    case (idx)
      stepd_pkg::CFG_LOWER:    if ($signed(d) <= 0) lo_lim = d;
      stepd_pkg::CFG_UPPER:    up_lim = d[30:0];
      stepd_pkg::CFG_RAMP:     if (d[3:0] <= 4'd9) ramp_set = d[3:0];
      stepd_pkg::CFG_HOMESPD:  home_spd = d[13:0];
      stepd_pkg::CFG_LSW_PRES: lsw_pres = d[0];
      stepd_pkg::CFG_USW_PRES: usw_pres = d[0];
      default: ;
    endcase
  endfunction

  function logic [31:0] ramp_inc();
    return (ramp_set == 0) ? 32'd0 : 32'(stepd_pkg::RAMP_SCALE * (10 - int'(ramp_set)));
  endfunction

  function void advance_coils();
    case (phase)
      2'd0: pattern = stepd_pkg::COIL_P0;
      2'd1: pattern = stepd_pkg::COIL_P1;
      2'd2: pattern = stepd_pkg::COIL_P2;
      default: pattern = stepd_pkg::COIL_P3;
    endcase
    phase = backward ? phase - 2'd1 : phase + 2'd1;
  endfunction

  function void begin_move(longint target, logic [13:0] spd);
    longint diff;
    logic [31:0] total, inc;
    diff = target - longint'(pos);
    total = 32'(diff < 0 ? -diff : diff);
    inc = ramp_inc();
    tgt = 32'(target);
    if (inc == 0) begin
      ramp_up = 0; vel = spd;
    end else begin
      ramp_up = spd / inc;
      vel = (ramp_up == 0) ? spd : 0;
    end
    if (longint'(total) > 2 * longint'(ramp_up)) begin
      ramp_dn = total - ramp_up;
    end else begin
      ramp_up = total / 2; ramp_dn = ramp_up;
    end
    backward = target < longint'(pos);
    delta = 0;
    next_t = now + 32'd10;
    mmode = stepd_pkg::ST_RUNNING;
  endfunction

  function void try_set_home();
    if (mmode == stepd_pkg::ST_ENABLED) begin
      pos = 0; delta = 0; homed = 1;
    end
  endfunction

  function logic [2:0] tick(logic lsw, logic usw, output logic st);
    longint np;
    logic [31:0] cnt, inc;
    st = 0;
    now = now + 1;
    if (!(homed && mmode == stepd_pkg::ST_RUNNING && now >= next_t))
      return stepd_pkg::EV_NONE;
    if (pos == tgt) begin
      mmode = stepd_pkg::ST_ENABLED; return stepd_pkg::EV_COMPLETE;
    end
    np = longint'(pos) + (backward ? -1 : 1);
    if (np < longint'(lo_lim)) begin
      mmode = stepd_pkg::ST_ENABLED; return stepd_pkg::EV_RANGE_LO;
    end
    if (np > longint'(up_lim)) begin
      mmode = stepd_pkg::ST_ENABLED; return stepd_pkg::EV_RANGE_UP;
    end
    advance_coils();
    st = 1;
    pos = 32'(np);
    delta = backward ? delta - 1 : delta + 1;
    if (lsw_pres && !lsw) begin
      mmode = stepd_pkg::ST_ENABLED; return stepd_pkg::EV_SW_LO;
    end
    if (usw_pres && !usw) begin
      mmode = stepd_pkg::ST_ENABLED; return stepd_pkg::EV_SW_UP;
    end
    cnt = delta[31] ? -delta : delta;
    inc = ramp_inc();
    if (cnt <= ramp_up) vel = vel + inc;
    else if (cnt > ramp_dn) vel = (vel > inc) ? vel - inc : 0;
    if (vel > 0) next_t = next_t + 32'd1000000 / vel;
    return stepd_pkg::EV_NONE;
  endfunction

  // Note an accepted input word and queue its expected result.
  function void note_input(logic [3:0] md, logic signed [31:0] arg, logic [13:0] spd,
                           logic lsw, logic usw);
    motor_word_t w;
    logic st;
    longint t;
    w.ev = stepd_pkg::EV_NONE; st = 0;
    case (md)
      stepd_pkg::MODE_TICK: w.ev = tick(lsw, usw, st);
      stepd_pkg::MODE_ABS:  begin_move(longint'(arg), spd);
      stepd_pkg::MODE_REL: if (arg != 0) begin
        t = longint'(pos) + longint'(arg);
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        begin_move(t, spd);
      end
      stepd_pkg::MODE_HOME:   begin_move(0, home_spd);
      stepd_pkg::MODE_TO_LOW: begin_move(longint'(lo_lim), home_spd);
      stepd_pkg::MODE_TO_UP:  begin_move(longint'({1'b0, up_lim}), home_spd);
      stepd_pkg::MODE_ENABLE: begin
        mmode = stepd_pkg::ST_ENABLED; advance_coils(); st = 1; try_set_home();
      end
      stepd_pkg::MODE_DISABLE: begin
        pattern = 0; mmode = stepd_pkg::ST_DISABLED; homed = 0;
      end
      stepd_pkg::MODE_ESTOP: begin
        pattern = 0; homed = 0; mmode = stepd_pkg::ST_ESTOP; tgt = pos;
      end
      stepd_pkg::MODE_SETHOME: try_set_home();
      default: ;
    endcase
    w.coil = pattern; w.status = mmode; w.pos = pos; w.moved = delta;
    w.homed = homed; w.stepped = st;
    if (st) steps_seen++;
    if (w.ev != stepd_pkg::EV_NONE) events_seen++;
    pending.push_back(w);
  endfunction

  function void check_result(motor_word_t got);
    motor_word_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result word, nothing pending", $time);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (got.coil !== e.coil) begin
      $display("%0t: coil_drive exp %h got %h", $time, e.coil, got.coil); errors++;
    end
    if (got.status !== e.status) begin
      $display("%0t: motor_status exp %0d got %0d", $time, e.status, got.status); errors++;
    end
    if (got.ev !== e.ev) begin
      $display("%0t: run_event exp %0d got %0d", $time, e.ev, got.ev); errors++;
    end
    if (got.pos !== e.pos) begin
      $display("%0t: current_position exp %0d got %0d", $time, e.pos, got.pos); errors++;
    end
    if (got.moved !== e.moved) begin
      $display("%0t: moved_steps exp %0d got %0d", $time, e.moved, got.moved); errors++;
    end
    if (got.homed !== e.homed) begin
      $display("%0t: is_homed exp %b got %b", $time, e.homed, got.homed); errors++;
    end
    if (got.stepped !== e.stepped) begin
      $display("%0t: stepped exp %b got %b", $time, e.stepped, got.stepped); errors++;
    end
  endfunction
endclass

module tb_stepper_trapezoid_step_generator;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [3:0] in_mode = '0;
  logic signed [31:0] in_target_or_steps = '0;
  logic [13:0] in_speed = '0;
  logic in_lower_switch = 1;
  logic in_upper_switch = 1;
  logic out_valid;
  logic out_ready = 0;
  logic [3:0] out_coil_drive;
  logic [2:0] out_motor_status;
  logic [2:0] out_run_event;
  logic signed [31:0] out_current_position;
  logic signed [31:0] out_moved_steps;
  logic out_is_homed;
  logic out_stepped;

  // Idle percentages of each side; changed per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 0;   // long receiver hold-off for backpressure
  int idle_wd = 0;
  int words_sent = 0;

  motor_scoreboard sb;

  stepper_trapezoid_step_generator uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Sample on the edge: note inputs and check outputs as they were accepted.
  always @(posedge clk) begin
    motor_word_t w;
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_input(in_mode, in_target_or_steps, in_speed, in_lower_switch,
                      in_upper_switch);
      if (out_valid && out_ready) begin
        w.coil = out_coil_drive; w.status = out_motor_status; w.ev = out_run_event;
        w.pos = out_current_position; w.moved = out_moved_steps;
        w.homed = out_is_homed; w.stepped = out_stepped;
        sb.check_result(w);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_wd <= 0;
      else idle_wd <= idle_wd + 1;
    end
  end

  // Receiver: stall at random, or hold off entirely while recv_hold is set.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 0;
    else out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (idle_wd >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, no handshake for %0d cycles", $time, idle_wd);
      $display("status: fail");
      $finish;
    end
  end

  // Offer one word and hold it until accepted; optional random gap first.
  // Valid stays high after the accept, so the next word can follow at once.
  task automatic send_word(logic [3:0] md, logic signed [31:0] arg, logic [13:0] spd,
                           logic lsw, logic usw);
    if ($urandom_range(99) < send_idle_pct) begin
      // drop valid for the gap
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1; in_mode <= md; in_target_or_steps <= arg; in_speed <= spd;
    in_lower_switch <= lsw; in_upper_switch <= usw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_tick(logic lsw, logic usw);
    send_word(stepd_pkg::MODE_TICK, $urandom, $urandom_range(16383), lsw, usw);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] d);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Command words mostly, with random content; the rest carry a random mode.
  task automatic random_command();
    int r;
    logic signed [31:0] arg;
    r = $urandom_range(99);
    case ($urandom_range(3))
      0: arg = $urandom;
      1: arg = $signed(32'($urandom_range(60))) - 30;
      2: arg = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: arg = $signed(32'($urandom_range(400))) - 200;
    endcase
    if (r < 30) send_word(stepd_pkg::MODE_REL, arg, $urandom_range(1) ? $urandom_range(16383)
                          : $urandom_range(3000), 1, 1);
    else if (r < 45) send_word(stepd_pkg::MODE_ABS, arg, $urandom_range(16383), 1, 1);
    else if (r < 55) send_word(stepd_pkg::MODE_ENABLE, arg, $urandom, 1, 1);
    else if (r < 62) send_word(stepd_pkg::MODE_SETHOME, arg, $urandom, 1, 1);
    else if (r < 68) send_word(stepd_pkg::MODE_HOME, arg, $urandom, 1, 1);
    else if (r < 72) send_word(stepd_pkg::MODE_TO_LOW, arg, $urandom, 1, 1);
    else if (r < 76) send_word(stepd_pkg::MODE_TO_UP, arg, $urandom, 1, 1);
    else if (r < 82) send_word(stepd_pkg::MODE_DISABLE, arg, $urandom, 1, 1);
    else if (r < 87) send_word(stepd_pkg::MODE_ESTOP, arg, $urandom, 1, 1);
    else send_word(4'($urandom_range(15)), arg, $urandom, $urandom, $urandom);
  endtask

  // One random command, at times after an enable, with a run of ticks behind it, switches mostly open.
  task automatic random_burst(int n);
    int k;
    if ($urandom_range(3) == 0) send_word(stepd_pkg::MODE_ENABLE, 0, 0, 1, 1);
    random_command();
    for (k = 0; k < n; k++)
      send_tick($urandom_range(49) != 0, $urandom_range(49) != 0);
  endtask

  task automatic run_phase(int sidle, int rstall, int n);
    send_idle_pct = sidle; recv_stall_pct = rstall;
    while (n > 0) begin
      random_burst($urandom_range(4, 30));
      n -= 20;
    end
    drain();
  endtask

  task automatic random_config();
    write_cfg(stepd_pkg::CFG_LOWER, $urandom_range(1) ? -$urandom_range(40) : $urandom);
    write_cfg(stepd_pkg::CFG_UPPER, $urandom_range(1) ? $urandom_range(40) : $urandom);
    write_cfg(stepd_pkg::CFG_RAMP, $urandom_range(15));
    write_cfg(stepd_pkg::CFG_HOMESPD, $urandom_range(2) == 0 ? $urandom_range(16383)
                                                             : $urandom_range(2000));
    write_cfg(stepd_pkg::CFG_LSW_PRES, $urandom);
    write_cfg(stepd_pkg::CFG_USW_PRES, $urandom);
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: most commands, unhomed moves, enable and home, ramps and limits.
    send_word(stepd_pkg::MODE_TICK, 0, 0, 0, 0);
    send_word(stepd_pkg::MODE_ABS, 5, 100, 1, 1);           // move while not homed
    send_word(stepd_pkg::MODE_TICK, 0, 0, 1, 1);
    send_word(stepd_pkg::MODE_SETHOME, 0, 0, 1, 1);         // ignored, not enabled
    send_word(stepd_pkg::MODE_ENABLE, 0, 0, 1, 1);
    send_word(stepd_pkg::MODE_SETHOME, 0, 0, 1, 1);
    send_word(stepd_pkg::MODE_REL, 0, 500, 1, 1);           // zero relative move
    send_word(stepd_pkg::MODE_REL, 32'h7fffffff, 16383, 1, 1);
    send_word(stepd_pkg::MODE_REL, 32'h80000000, 0, 1, 1);  // most negative step count, zero speed
    send_word(stepd_pkg::MODE_REL, 3, 0, 1, 1);
    repeat (14) send_tick(1, 1);
    send_word(stepd_pkg::MODE_ESTOP, 0, 0, 1, 1);
    send_word(stepd_pkg::MODE_DISABLE, 0, 0, 1, 1);
    send_word(4'd15, -1, 16383, 1, 1);                      // unused mode
    drain();

    // Extremes of the configuration, then tight limits and switches fitted.
    write_cfg(stepd_pkg::CFG_LOWER, 32'h80000000);
    write_cfg(stepd_pkg::CFG_UPPER, 32'h7fffffff);
    write_cfg(stepd_pkg::CFG_RAMP, 4'd9);
    write_cfg(stepd_pkg::CFG_HOMESPD, 14'd9999);
    write_cfg(stepd_pkg::CFG_LSW_PRES, 1);
    write_cfg(stepd_pkg::CFG_USW_PRES, 1);
    send_word(stepd_pkg::MODE_ENABLE, 0, 0, 1, 1);
    send_word(stepd_pkg::MODE_TO_UP, 0, 0, 1, 1);
    repeat (12) send_tick(1, 1);
    send_tick(1, 0);
    drain();
    write_cfg(stepd_pkg::CFG_LOWER, 32'd5);                 // positive, ignored
    write_cfg(stepd_pkg::CFG_LOWER, -32'sd3);
    write_cfg(stepd_pkg::CFG_UPPER, 32'd2);
    write_cfg(stepd_pkg::CFG_RAMP, 4'd0);
    write_cfg(stepd_pkg::CFG_HOMESPD, 14'd1);
    write_cfg(stepd_pkg::CFG_RAMP, 4'd12);                  // out of range, ignored
    send_word(stepd_pkg::MODE_ENABLE, 0, 0, 1, 1);
    send_word(stepd_pkg::MODE_TO_LOW, 0, 0, 1, 1);
    drain();

    run_phase(0, 0, 300);
    random_config();
    run_phase(80, 0, 250);
    random_config();
    run_phase(0, 80, 250);
    random_config();
    run_phase(31, 31, 300);

    // Backpressure: hold the receiver off while words keep coming.
    send_idle_pct = 0; recv_stall_pct = 0;
    fork
      begin
        recv_hold = 1;
        repeat (300) @(posedge clk);
        recv_hold = 0;
      end
      begin
        send_word(stepd_pkg::MODE_ENABLE, 0, 0, 1, 1);
        repeat (20) send_tick(1, 1);
      end
    join
    drain();
    write_cfg(stepd_pkg::CFG_LOWER, -32'sd2000000000);
    write_cfg(stepd_pkg::CFG_UPPER, 32'd2000000000);
    write_cfg(stepd_pkg::CFG_RAMP, 4'd5);
    write_cfg(stepd_pkg::CFG_LSW_PRES, 0);
    write_cfg(stepd_pkg::CFG_USW_PRES, 0);
    run_phase(0, 0, 300);

    drain();
    $display("Sent %0d words, checked %0d results: %0d coil steps, %0d run events.",
             words_sent, sb.checked, sb.steps_seen, sb.events_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/stepd_pkg.sv
rtl/stepd_div.sv
rtl/stepd_datapath.sv
rtl/stepd_ctrl.sv
rtl/stepper_trapezoid_step_generator.sv
rtl/stepd_checker.sv
tb/sv/tb_stepper_trapezoid_step_generator.sv
